// ----- hdl/pss_pkg.sv -----
package pss_pkg;

  localparam int PSS_MAX_LEN = 32;
  localparam int PSS_NRULE   = 50;
  localparam int PSS_T3      = 22;
  localparam int PSS_T4      = 30;
  localparam int PSS_ION     = 41;

  typedef logic [6:0][7:0] sfx_t;
  typedef logic [3:0][7:0] rep_t;

  typedef struct packed {
    sfx_t       sfx;
    logic [2:0] sl;
    rep_t       rep;
    logic [2:0] rl;
  } rule_t;

  typedef struct packed {
    logic [1:0] m;
    logic       hv;
    logic       cvc;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       f1;
    logic [1:0] cnt;
  } scan_res_t;

  typedef enum logic [5:0] {
    ST_LOAD, ST_S1A_R, ST_S1A2, ST_S1A3, ST_S1A4,
    ST_S1B, ST_S1B1, ST_S1B2, ST_S1B3, ST_S1B4, ST_S1B5, ST_S1B6, ST_S1B7,
    ST_S1B8, ST_S1B9, ST_ADD_E, ST_S1C, ST_S1C1, ST_S1C2, ST_PUT_I,
    ST_TAB, ST_TAB1, ST_TAB2, ST_REPL,
    ST_S5, ST_S51, ST_S52, ST_S53, ST_S5L, ST_S5L1, ST_S5L2,
    ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_W,
    ST_E0, ST_E_RD, ST_E_CMP, ST_M0, ST_M_RD, ST_M_FD
  } state_t;

  function automatic rule_t mk(input logic [55:0] s, input logic [2:0] sl,
                               input logic [31:0] r, input logic [2:0] rl);
    rule_t e;
    e.sfx = s;
    e.sl  = sl;
    e.rep = r;
    e.rl  = rl;
    return e;
  endfunction

  // suffix and replacement are stored last character first in byte 0
  function automatic rule_t pss_rule(input logic [5:0] k);
    rule_t e;
    case (k)
      6'd0:  e = mk(56'("ational"), 3'd7, 32'("ate"), 3'd3);
      6'd1:  e = mk(56'("tional"), 3'd6, 32'("tion"), 3'd4);
      6'd2:  e = mk(56'("enci"), 3'd4, 32'("ence"), 3'd4);
      6'd3:  e = mk(56'("anci"), 3'd4, 32'("ance"), 3'd4);
      6'd4:  e = mk(56'("izer"), 3'd4, 32'("ize"), 3'd3);
      6'd5:  e = mk(56'("iser"), 3'd4, 32'("ize"), 3'd3);
      6'd6:  e = mk(56'("abli"), 3'd4, 32'("able"), 3'd4);
      6'd7:  e = mk(56'("alli"), 3'd4, 32'("al"), 3'd2);
      6'd8:  e = mk(56'("entli"), 3'd5, 32'("ent"), 3'd3);
      6'd9:  e = mk(56'("eli"), 3'd3, 32'("e"), 3'd1);
      6'd10: e = mk(56'("ousli"), 3'd5, 32'("ous"), 3'd3);
      6'd11: e = mk(56'("ization"), 3'd7, 32'("ize"), 3'd3);
      6'd12: e = mk(56'("isation"), 3'd7, 32'("ize"), 3'd3);
      6'd13: e = mk(56'("ation"), 3'd5, 32'("ate"), 3'd3);
      6'd14: e = mk(56'("ator"), 3'd4, 32'("ate"), 3'd3);
      6'd15: e = mk(56'("alism"), 3'd5, 32'("al"), 3'd2);
      6'd16: e = mk(56'("iveness"), 3'd7, 32'("ive"), 3'd3);
      6'd17: e = mk(56'("fulness"), 3'd7, 32'("ful"), 3'd3);
      6'd18: e = mk(56'("ousness"), 3'd7, 32'("ous"), 3'd3);
      6'd19: e = mk(56'("aliti"), 3'd5, 32'("al"), 3'd2);
      6'd20: e = mk(56'("iviti"), 3'd5, 32'("ive"), 3'd3);
      6'd21: e = mk(56'("biliti"), 3'd6, 32'("ble"), 3'd3);
      6'd22: e = mk(56'("icate"), 3'd5, 32'("ic"), 3'd2);
      6'd23: e = mk(56'("ative"), 3'd5, 32'h0, 3'd0);
      6'd24: e = mk(56'("alize"), 3'd5, 32'("al"), 3'd2);
      6'd25: e = mk(56'("alise"), 3'd5, 32'("al"), 3'd2);
      6'd26: e = mk(56'("iciti"), 3'd5, 32'("ic"), 3'd2);
      6'd27: e = mk(56'("ical"), 3'd4, 32'("ic"), 3'd2);
      6'd28: e = mk(56'("ful"), 3'd3, 32'h0, 3'd0);
      6'd29: e = mk(56'("ness"), 3'd4, 32'h0, 3'd0);
      6'd30: e = mk(56'("al"), 3'd2, 32'h0, 3'd0);
      6'd31: e = mk(56'("ance"), 3'd4, 32'h0, 3'd0);
      6'd32: e = mk(56'("ence"), 3'd4, 32'h0, 3'd0);
      6'd33: e = mk(56'("er"), 3'd2, 32'h0, 3'd0);
      6'd34: e = mk(56'("ic"), 3'd2, 32'h0, 3'd0);
      6'd35: e = mk(56'("able"), 3'd4, 32'h0, 3'd0);
      6'd36: e = mk(56'("ible"), 3'd4, 32'h0, 3'd0);
      6'd37: e = mk(56'("ant"), 3'd3, 32'h0, 3'd0);
      6'd38: e = mk(56'("ement"), 3'd5, 32'h0, 3'd0);
      6'd39: e = mk(56'("ment"), 3'd4, 32'h0, 3'd0);
      6'd40: e = mk(56'("ent"), 3'd3, 32'h0, 3'd0);
      6'd41: e = mk(56'("ion"), 3'd3, 32'h0, 3'd0);
      6'd42: e = mk(56'("ou"), 3'd2, 32'h0, 3'd0);
      6'd43: e = mk(56'("ism"), 3'd3, 32'h0, 3'd0);
      6'd44: e = mk(56'("ate"), 3'd3, 32'h0, 3'd0);
      6'd45: e = mk(56'("iti"), 3'd3, 32'h0, 3'd0);
      6'd46: e = mk(56'("ous"), 3'd3, 32'h0, 3'd0);
      6'd47: e = mk(56'("ive"), 3'd3, 32'h0, 3'd0);
      6'd48: e = mk(56'("ize"), 3'd3, 32'h0, 3'd0);
      6'd49: e = mk(56'("ise"), 3'd3, 32'h0, 3'd0);
      default: e = mk(56'h0, 3'd7, 32'h0, 3'd0);
    endcase
    return e;
  endfunction

endpackage

// ----- hdl/pss_if.sv -----
interface pss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_in;
  modport source (output valid, ch, last_in, input ready);
  modport sink   (input valid, ch, last_in, output ready);
endinterface

interface pss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_ch;
  logic       last_out;
  logic       too_long;
  modport source (output valid, out_ch, last_out, too_long, input ready);
  modport sink   (input valid, out_ch, last_out, too_long, output ready);
endinterface

// ----- hdl/pss_mem.sv -----
module pss_mem #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pss_scan.sv -----
module pss_scan import pss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      clr,
  input  logic      feed,
  input  logic      first,
  input  logic [7:0] ch,
  output scan_res_t res
);

  logic [1:0] m_r;
  logic       hv_r;
  logic [7:0] c1_r;
  logic [7:0] c2_r;
  logic       f1_r;
  logic       f2_r;
  logic       f3_r;
  logic [1:0] cnt_r;
  logic       v;

  always_comb begin
    v = (ch == 8'("a")) || (ch == 8'("e")) || (ch == 8'("i")) ||
        (ch == 8'("o")) || (ch == 8'("u")) ||
        ((ch == 8'("y")) && !first && !f1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      m_r   <= 2'd0;
      hv_r  <= 1'b0;
      c1_r  <= 8'd0;
      c2_r  <= 8'd0;
      f1_r  <= 1'b0;
      f2_r  <= 1'b0;
      f3_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else if (feed) begin
      if (!first && f1_r && !v && (m_r != 2'd2)) begin
        m_r <= m_r + 2'd1;
      end
      hv_r <= hv_r | v;
      c2_r <= c1_r;
      c1_r <= ch;
      f3_r <= f2_r;
      f2_r <= f1_r;
      f1_r <= v;
      if (cnt_r != 2'd3) begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_comb begin
    res.m   = m_r;
    res.hv  = hv_r;
    res.cvc = (cnt_r == 2'd3) && !f1_r && f2_r && !f3_r &&
              (c1_r != 8'("w")) && (c1_r != 8'("x")) && (c1_r != 8'("y"));
    res.c1  = c1_r;
    res.c2  = c2_r;
    res.f1  = f1_r;
    res.cnt = cnt_r;
  end

endmodule

// ----- hdl/porter_suffix_stemmer.sv -----
// Porter stemmer for lower-case words. Feed a word one character per word
// transfer, marking its final character with last_in; the stem comes back one
// character per transfer with last_out on its final character. Loading accepts
// one character per cycle. Stemming then runs on a word RAM with one write and
// one read port under a sequencer: every suffix test checks the length, then
// reads and compares each suffix character, every step-2/3/4 table entry passes
// through ST_TAB and ST_TAB1, and every measure/cvc scan clears the scanner,
// then reads and feeds each stem character. A word goes through about sixty
// suffix tests; stemming time is set by how far the fifty-entry table is walked
// and by how many suffixes match. Output reads, registers and holds each stem
// character until it is taken. No new word is taken until the last stem
// character leaves. Words of two characters or fewer pass unchanged; words
// longer than MAX_LEN come back truncated, unstemmed and with too_long set.
module porter_suffix_stemmer import pss_pkg::*; #(
  parameter int MAX_LEN = PSS_MAX_LEN
) (
  input  logic      clk,
  input  logic      rst_n,
  pss_in_if.sink    in_chan,
  pss_out_if.source out_chan
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam logic [LW-1:0] FULL = LW'(MAX_LEN);

  state_t       state_r, state_nxt, ret_r, ret_nxt;
  sfx_t         sfx_r, sfx_nxt;
  logic [2:0]   sl_r, sl_nxt;
  logic [1:0]   s1_r, s1_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] n_r, n_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] stem_r, stem_nxt;
  logic [5:0]   k_r, k_nxt;
  logic         ovf_r, ovf_nxt;
  logic         res_r, res_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  logic          clr, feed, first;
  scan_res_t     sc;
  rule_t         rule;
  logic [2:0]    bidx, ridx;
  logic          in_acc, out_acc, tab_ok;

  logic       out_valid_r;
  logic [7:0] out_ch_r;
  logic       last_r;
  logic       too_long_r;

  pss_mem #(.DEPTH(MAX_LEN)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pss_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr),
    .feed  (feed),
    .first (first),
    .ch    (rdata),
    .res   (sc)
  );

  assign rule    = pss_rule(k_r);
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_valid_r && out_chan.ready;
  assign bidx    = sl_r - 3'd1 - idx_r[2:0];
  assign ridx    = rule.rl - 3'd1 - idx_r[2:0];

  always_comb begin
    if (k_r < 6'(PSS_T4)) begin
      tab_ok = (sc.m != 2'd0);
    end else begin
      tab_ok = (sc.m == 2'd2) &&
               !((k_r == 6'(PSS_ION)) && (sc.c1 != 8'("s")) && (sc.c1 != 8'("t")));
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    sfx_nxt   = sfx_r;
    sl_nxt    = sl_r;
    s1_nxt    = s1_r;
    len_nxt   = len_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    stem_nxt  = stem_r;
    k_nxt     = k_r;
    ovf_nxt   = ovf_r;
    res_nxt   = res_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (n_r != FULL) begin
            n_nxt = n_r + LW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_chan.last_in) begin
            if (ovf_r || (n_r == FULL) || (n_r < LW'(2))) begin
              idx_nxt   = '0;
              state_nxt = ST_EMIT_RD;
            end else begin
              sfx_nxt = 56'("s"); sl_nxt = 3'd1; ret_nxt = ST_S1A_R; state_nxt = ST_E0;
            end
          end
        end
      end
      ST_S1A_R: begin
        if (res_r) begin
          sfx_nxt = 56'("sses"); sl_nxt = 3'd4; ret_nxt = ST_S1A2; state_nxt = ST_E0;
        end else begin
          state_nxt = ST_S1B;
        end
      end
      ST_S1A2: begin
        if (res_r) begin
          n_nxt = n_r - LW'(2); state_nxt = ST_S1B;
        end else begin
          sfx_nxt = 56'("ies"); sl_nxt = 3'd3; ret_nxt = ST_S1A3; state_nxt = ST_E0;
        end
      end
      ST_S1A3: begin
        if (res_r) begin
          n_nxt = n_r - LW'(2); state_nxt = ST_S1B;
        end else begin
          sfx_nxt = 56'("ss"); sl_nxt = 3'd2; ret_nxt = ST_S1A4; state_nxt = ST_E0;
        end
      end
      ST_S1A4: begin
        if (!res_r) begin
          n_nxt = n_r - LW'(1);
        end
        state_nxt = ST_S1B;
      end
      ST_S1B: begin
        sfx_nxt = 56'("eed"); sl_nxt = 3'd3; ret_nxt = ST_S1B1; state_nxt = ST_E0;
      end
      ST_S1B1: begin
        if (res_r) begin
          len_nxt = n_r - LW'(3); ret_nxt = ST_S1B2; state_nxt = ST_M0;
        end else begin
          sfx_nxt = 56'("ed"); sl_nxt = 3'd2; ret_nxt = ST_S1B3; state_nxt = ST_E0;
        end
      end
      ST_S1B2: begin
        if (sc.m != 2'd0) begin
          n_nxt = n_r - LW'(1);
        end
        state_nxt = ST_S1C;
      end
      ST_S1B3: begin
        if (res_r) begin
          s1_nxt = 2'd2; len_nxt = n_r - LW'(2); ret_nxt = ST_S1B5; state_nxt = ST_M0;
        end else begin
          sfx_nxt = 56'("ing"); sl_nxt = 3'd3; ret_nxt = ST_S1B4; state_nxt = ST_E0;
        end
      end
      ST_S1B4: begin
        if (res_r) begin
          s1_nxt = 2'd3; len_nxt = n_r - LW'(3); ret_nxt = ST_S1B5; state_nxt = ST_M0;
        end else begin
          state_nxt = ST_S1C;
        end
      end
      ST_S1B5: begin
        if (sc.hv) begin
          n_nxt   = n_r - LW'(s1_r);
          sfx_nxt = 56'("at"); sl_nxt = 3'd2; ret_nxt = ST_S1B6; state_nxt = ST_E0;
        end else begin
          state_nxt = ST_S1C;
        end
      end
      ST_S1B6: begin
        if (res_r) begin
          state_nxt = ST_ADD_E;
        end else begin
          sfx_nxt = 56'("bl"); sl_nxt = 3'd2; ret_nxt = ST_S1B7; state_nxt = ST_E0;
        end
      end
      ST_S1B7: begin
        if (res_r) begin
          state_nxt = ST_ADD_E;
        end else begin
          sfx_nxt = 56'("iz"); sl_nxt = 3'd2; ret_nxt = ST_S1B8; state_nxt = ST_E0;
        end
      end
      ST_S1B8: begin
        if (res_r) begin
          state_nxt = ST_ADD_E;
        end else begin
          len_nxt = n_r; ret_nxt = ST_S1B9; state_nxt = ST_M0;
        end
      end
      ST_S1B9: begin
        if ((sc.cnt >= 2'd2) && (sc.c1 == sc.c2) && !sc.f1 && (sc.c1 != 8'("l")) &&
            (sc.c1 != 8'("s")) && (sc.c1 != 8'("z"))) begin
          n_nxt = n_r - LW'(1); state_nxt = ST_S1C;
        end else if ((sc.m == 2'd1) && sc.cvc) begin
          state_nxt = ST_ADD_E;
        end else begin
          state_nxt = ST_S1C;
        end
      end
      ST_ADD_E: begin
        n_nxt = n_r + LW'(1); state_nxt = ST_S1C;
      end
      ST_S1C: begin
        sfx_nxt = 56'("y"); sl_nxt = 3'd1; ret_nxt = ST_S1C1; state_nxt = ST_E0;
      end
      ST_S1C1: begin
        if (res_r) begin
          len_nxt = n_r - LW'(1); ret_nxt = ST_S1C2; state_nxt = ST_M0;
        end else begin
          k_nxt = '0; state_nxt = ST_TAB;
        end
      end
      ST_S1C2: begin
        k_nxt = '0;
        state_nxt = sc.hv ? ST_PUT_I : ST_TAB;
      end
      ST_PUT_I: begin
        state_nxt = ST_TAB;
      end
      ST_TAB: begin
        if (k_r == 6'(PSS_NRULE)) begin
          state_nxt = ST_S5;
        end else begin
          sfx_nxt = rule.sfx; sl_nxt = rule.sl; ret_nxt = ST_TAB1; state_nxt = ST_E0;
        end
      end
      ST_TAB1: begin
        if (res_r) begin
          stem_nxt = n_r - LW'(sl_r);
          len_nxt  = n_r - LW'(sl_r);
          ret_nxt  = ST_TAB2;
          state_nxt = ST_M0;
        end else begin
          k_nxt = k_r + 6'd1; state_nxt = ST_TAB;
        end
      end
      ST_TAB2: begin
        if (tab_ok) begin
          idx_nxt = '0; state_nxt = ST_REPL;
        end else begin
          k_nxt = k_r + 6'd1; state_nxt = ST_TAB;
        end
      end
      ST_REPL: begin
        if (idx_r == LW'(rule.rl)) begin
          n_nxt = stem_r + LW'(rule.rl);
          if (k_r < 6'(PSS_T3)) begin
            k_nxt = 6'(PSS_T3);
          end else if (k_r < 6'(PSS_T4)) begin
            k_nxt = 6'(PSS_T4);
          end else begin
            k_nxt = 6'(PSS_NRULE);
          end
          state_nxt = ST_TAB;
        end else begin
          idx_nxt = idx_r + LW'(1);
        end
      end
      ST_S5: begin
        sfx_nxt = 56'("e"); sl_nxt = 3'd1; ret_nxt = ST_S51; state_nxt = ST_E0;
      end
      ST_S51: begin
        if (res_r) begin
          len_nxt = n_r; ret_nxt = ST_S52; state_nxt = ST_M0;
        end else begin
          state_nxt = ST_S5L;
        end
      end
      ST_S52: begin
        if (sc.m == 2'd2) begin
          n_nxt = n_r - LW'(1); state_nxt = ST_S5L;
        end else if (sc.m == 2'd1) begin
          len_nxt = n_r - LW'(1); ret_nxt = ST_S53; state_nxt = ST_M0;
        end else begin
          state_nxt = ST_S5L;
        end
      end
      ST_S53: begin
        if (!sc.cvc) begin
          n_nxt = n_r - LW'(1);
        end
        state_nxt = ST_S5L;
      end
      ST_S5L: begin
        sfx_nxt = 56'("ll"); sl_nxt = 3'd2; ret_nxt = ST_S5L1; state_nxt = ST_E0;
      end
      ST_S5L1: begin
        if (res_r) begin
          len_nxt = n_r; ret_nxt = ST_S5L2; state_nxt = ST_M0;
        end else begin
          idx_nxt = '0; state_nxt = ST_EMIT_RD;
        end
      end
      ST_S5L2: begin
        if (sc.m == 2'd2) begin
          n_nxt = n_r - LW'(1);
        end
        idx_nxt = '0; state_nxt = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        state_nxt = ST_EMIT_W;
      end
      ST_EMIT_W: begin
        if (out_acc) begin
          if (idx_r + LW'(1) == n_r) begin
            n_nxt = '0; ovf_nxt = 1'b0; state_nxt = ST_LOAD;
          end else begin
            idx_nxt = idx_r + LW'(1); state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_E0: begin
        if (LW'(sl_r) >= n_r) begin
          res_nxt = 1'b0; state_nxt = ret_r;
        end else begin
          idx_nxt = '0; state_nxt = ST_E_RD;
        end
      end
      ST_E_RD: begin
        state_nxt = ST_E_CMP;
      end
      ST_E_CMP: begin
        if (rdata != sfx_r[bidx]) begin
          res_nxt = 1'b0; state_nxt = ret_r;
        end else if (idx_r + LW'(1) == LW'(sl_r)) begin
          res_nxt = 1'b1; state_nxt = ret_r;
        end else begin
          idx_nxt = idx_r + LW'(1); state_nxt = ST_E_RD;
        end
      end
      ST_M0: begin
        if (len_r == '0) begin
          state_nxt = ret_r;
        end else begin
          idx_nxt = '0; state_nxt = ST_M_RD;
        end
      end
      ST_M_RD: begin
        state_nxt = ST_M_FD;
      end
      ST_M_FD: begin
        idx_nxt = idx_r + LW'(1);
        state_nxt = (idx_r + LW'(1) == len_r) ? ret_r : ST_M_RD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    we    = 1'b0;
    waddr = AW'(n_r);
    wdata = in_chan.ch;
    raddr = AW'(idx_r);
    clr   = 1'b0;
    feed  = 1'b0;
    first = (idx_r == '0);
    in_chan.ready = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_chan.ready = 1'b1;
        we = in_chan.valid && (n_r != FULL);
      end
      ST_ADD_E: begin
        we = 1'b1; wdata = 8'("e");
      end
      ST_PUT_I: begin
        we = 1'b1; wdata = 8'("i"); waddr = AW'(n_r - LW'(1));
      end
      ST_REPL: begin
        we    = (idx_r != LW'(rule.rl));
        waddr = AW'(stem_r + idx_r);
        wdata = rule.rep[ridx[1:0]];
      end
      ST_E_RD: begin
        raddr = AW'(n_r - LW'(sl_r) + idx_r);
      end
      ST_M0: begin
        clr = 1'b1;
      end
      ST_M_FD: begin
        feed = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ret_r   <= ST_LOAD;
      sl_r    <= '0;
      s1_r    <= '0;
      len_r   <= '0;
      n_r     <= '0;
      idx_r   <= '0;
      stem_r  <= '0;
      k_r     <= '0;
      ovf_r   <= 1'b0;
      res_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      sl_r    <= sl_nxt;
      s1_r    <= s1_nxt;
      len_r   <= len_nxt;
      n_r     <= n_nxt;
      idx_r   <= idx_nxt;
      stem_r  <= stem_nxt;
      k_r     <= k_nxt;
      ovf_r   <= ovf_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sfx_r <= sfx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT_LD) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT_LD) begin
      out_ch_r   <= rdata;
      last_r     <= (idx_r + LW'(1) == n_r);
      too_long_r <= ovf_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_ch   = out_ch_r;
  assign out_chan.last_out = last_r;
  assign out_chan.too_long = too_long_r;

endmodule
